FILE: hdl/bkim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkim_pkg
// Control word layout and microprogram for the key/index map sequencer.
// ----------------------------------------------------------------------------
package bkim_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_ICHK,
        S_IEMPTY,
        S_IRD,
        S_ICMP,
        S_IWLINK,
        S_IWNEW,
        S_REFUSE,
        S_FCHK,
        S_FMISS,
        S_FRD,
        S_FCMP,
        S_FEND
    } t_step;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_FIND,
        C_FULL,
        C_EMPTY,
        C_ISTOP,
        C_FSTOP
    } t_cond;

    typedef enum logic [2:0] {
        M_NONE,
        M_RD,
        M_RD_NEXT,
        M_WR_LINK,
        M_WR_NEW
    } t_mem;

    typedef enum logic [2:0] {
        E_NONE,
        E_INS_OK,
        E_INS_FULL,
        E_FIND_MISS,
        E_FIND_WORD
    } t_emit;

    typedef struct packed {
        t_cond cond;
        t_mem  mem;
        t_emit emit;
        logic  idle;
        logic  ld_word;
        logic  inc_used;
        t_step jmp_t;
        t_step jmp_f;
    } t_ctrl;

    function automatic t_ctrl bkim_rom(input t_step s);
        t_ctrl c;
        c = '{cond: C_ALWAYS, mem: M_NONE, emit: E_NONE, idle: 1'b0, ld_word: 1'b0,
              inc_used: 1'b0, jmp_t: S_IDLE, jmp_f: S_IDLE};
        case (s)
            S_IDLE: begin
                c.idle  = 1'b1;
                c.cond  = C_START;
                c.jmp_t = S_DISP;
                c.jmp_f = S_IDLE;
            end
            S_DISP: begin
                c.cond  = C_FIND;
                c.jmp_t = S_FCHK;
                c.jmp_f = S_ICHK;
            end
            S_ICHK: begin
                c.cond  = C_FULL;
                c.jmp_t = S_REFUSE;
                c.jmp_f = S_IEMPTY;
            end
            S_IEMPTY: begin
                c.cond  = C_EMPTY;
                c.jmp_t = S_IWNEW;
                c.jmp_f = S_IRD;
            end
            S_IRD: begin
                c.mem   = M_RD;
                c.jmp_t = S_ICMP;
            end
            S_ICMP: begin
                c.cond    = C_ISTOP;
                c.mem     = M_RD_NEXT;
                c.ld_word = 1'b1;
                c.jmp_t   = S_IWLINK;
                c.jmp_f   = S_ICMP;
            end
            S_IWLINK: begin
                c.mem   = M_WR_LINK;
                c.jmp_t = S_IWNEW;
            end
            S_IWNEW: begin
                c.mem      = M_WR_NEW;
                c.inc_used = 1'b1;
                c.emit     = E_INS_OK;
                c.jmp_t    = S_IDLE;
            end
            S_REFUSE: begin
                c.emit  = E_INS_FULL;
                c.jmp_t = S_IDLE;
            end
            S_FCHK: begin
                c.cond  = C_EMPTY;
                c.jmp_t = S_FMISS;
                c.jmp_f = S_FRD;
            end
            S_FMISS: begin
                c.emit  = E_FIND_MISS;
                c.jmp_t = S_IDLE;
            end
            S_FRD: begin
                c.mem   = M_RD;
                c.jmp_t = S_FCMP;
            end
            S_FCMP: begin
                c.cond    = C_FSTOP;
                c.mem     = M_RD_NEXT;
                c.ld_word = 1'b1;
                c.jmp_t   = S_FEND;
                c.jmp_f   = S_FCMP;
            end
            S_FEND: begin
                c.emit  = E_FIND_WORD;
                c.jmp_t = S_IDLE;
            end
            default: begin
                c.jmp_t = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/bst_key_index_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_key_index_map_unit
// Unbalanced binary search tree in a fixed node pool, mapping keys to indices.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and the result shows
// on o_valid for one cycle, with busy already low in that cycle. The walk
// visits one node per cycle through the single node RAM port. A find walks
// from the root until it meets the key or an empty link; an insert into a
// non-empty tree walks to an empty link, writes the link into the parent,
// then the new node; a full pool refuses it. The receiver cannot stall:
// results must be taken when shown.
// ----------------------------------------------------------------------------
module bst_key_index_map_unit #(
    parameter int POOL_NODES  = 1024,
    parameter int VALUE_WIDTH = 16,
    parameter int KEY_WIDTH   = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_opcode,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    output logic                   o_found,
    output logic [VALUE_WIDTH-1:0] o_found_value,
    output logic                   o_status
);

    import bkim_pkg::*;

    localparam int LW = $clog2(POOL_NODES);
    localparam int UW = $clog2(POOL_NODES + 1);
    localparam int W  = KEY_WIDTH + VALUE_WIDTH + 2 * LW;

    t_step                  r_pc, n_pc;
    t_ctrl                  ctrl;
    logic                   r_find;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [LW-1:0]          r_cur, n_cur;
    logic [W-1:0]           r_word, n_word;
    logic [UW-1:0]          r_used, n_used;
    logic                   r_valid, n_valid;
    logic                   r_found, n_found;
    logic [VALUE_WIDTH-1:0] r_found_value, n_found_value;
    logic                   r_status, n_status;

    logic                   accept;
    logic                   cond_true;
    logic [W-1:0]           rdata;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [LW-1:0]          rd_left, rd_right, next_link;
    logic                   link_empty;
    logic [KEY_WIDTH-1:0]   wd_key;
    logic [VALUE_WIDTH-1:0] wd_value;
    logic                   wd_right;
    logic                   mem_we, mem_re;
    logic [LW-1:0]          mem_addr;
    logic [W-1:0]           mem_wdata;

    bkim_ram #(
        .WIDTH (W),
        .DEPTH (POOL_NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (rdata)
    );

    assign ctrl   = bkim_rom(r_pc);
    assign busy   = !ctrl.idle;
    assign accept = start && ctrl.idle;

    assign rd_key     = rdata[W-1 -: KEY_WIDTH];
    assign rd_left    = rdata[2*LW-1 -: LW];
    assign rd_right   = rdata[LW-1:0];
    assign next_link  = (rd_key <= r_key) ? rd_right : rd_left;
    assign link_empty = (next_link == '0);

    assign wd_key   = r_word[W-1 -: KEY_WIDTH];
    assign wd_value = r_word[2*LW +: VALUE_WIDTH];
    assign wd_right = (wd_key <= r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= S_IDLE;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
        if (accept) begin
            r_find  <= i_opcode;
            r_key   <= i_key;
            r_value <= i_value;
        end
        r_cur         <= n_cur;
        r_word        <= n_word;
        r_found       <= n_found;
        r_found_value <= n_found_value;
        r_status      <= n_status;
    end

    always_comb begin
        case (ctrl.cond)
            C_ALWAYS: cond_true = 1'b1;
            C_START:  cond_true = start;
            C_FIND:   cond_true = r_find;
            C_FULL:   cond_true = (r_used == UW'(POOL_NODES));
            C_EMPTY:  cond_true = (r_used == '0);
            C_ISTOP:  cond_true = link_empty;
            C_FSTOP:  cond_true = (rd_key == r_key) || link_empty;
            default:  cond_true = 1'b1;
        endcase

        n_pc          = cond_true ? ctrl.jmp_t : ctrl.jmp_f;
        n_cur         = accept ? '0 : r_cur;
        n_word        = ctrl.ld_word ? rdata : r_word;
        n_used        = ctrl.inc_used ? r_used + UW'(1) : r_used;
        n_valid       = 1'b0;
        n_found       = r_found;
        n_found_value = r_found_value;
        n_status      = r_status;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_cur;
        mem_wdata = {r_key, r_value, {LW{1'b0}}, {LW{1'b0}}};

        case (ctrl.mem)
            M_NONE: begin
            end
            M_RD: begin
                mem_re = 1'b1;
            end
            M_RD_NEXT: begin
                mem_re   = !cond_true;
                mem_addr = next_link;
                if (!cond_true) begin
                    n_cur = next_link;
                end
            end
            M_WR_LINK: begin
                mem_we = 1'b1;
                if (wd_right) begin
                    mem_wdata = {r_word[W-1:LW], r_used[LW-1:0]};
                end else begin
                    mem_wdata = {r_word[W-1:2*LW], r_used[LW-1:0], r_word[LW-1:0]};
                end
            end
            M_WR_NEW: begin
                mem_we   = 1'b1;
                mem_addr = r_used[LW-1:0];
            end
            default: begin
            end
        endcase

        case (ctrl.emit)
            E_NONE: begin
            end
            E_INS_OK, E_FIND_MISS: begin
                n_valid       = 1'b1;
                n_found       = 1'b0;
                n_found_value = '0;
                n_status      = 1'b0;
            end
            E_INS_FULL: begin
                n_valid       = 1'b1;
                n_found       = 1'b0;
                n_found_value = '0;
                n_status      = 1'b1;
            end
            E_FIND_WORD: begin
                n_valid       = 1'b1;
                n_found       = (wd_key == r_key);
                n_found_value = (wd_key == r_key) ? wd_value : '0;
                n_status      = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_found_value = r_found_value;
    assign o_status      = r_status;

endmodule

FILE: hdl/bkim_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkim_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bkim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bkim_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkim_chk
// Port-level checks on the key/index map handshake and result fields.
// ----------------------------------------------------------------------------
module bkim_chk #(
    parameter int VALUE_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_valid,
    input logic                   o_found,
    input logic [VALUE_WIDTH-1:0] o_found_value,
    input logic                   o_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted item did not raise busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result shown for more than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_refuse_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_found && o_found_value == '0)
        else $error("refused insert carries find fields");

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_found_value == '0)
        else $error("value reported without a match");

endmodule

bind bst_key_index_map_unit bkim_chk #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_bkim_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_found       (o_found),
    .o_found_value (o_found_value),
    .o_status      (o_status)
);
